### hdl/stdl_pkg.sv
`default_nettype none

package stdl_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int NAME_WIDTH_DEF  = 32;

	// port field widths
	localparam int KIND_W     = 3;
	localparam int NAME_ID_W  = 32;
	localparam int RIDX_W     = 6;
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR    = 3'd0,
		KIND_ARG      = 3'd1,
		KIND_EXTERN   = 3'd2,
		KIND_AUTO     = 3'd3,
		KIND_INTERNAL = 3'd4,
		KIND_LOOKUP   = 3'd5,
		KIND_COUNT    = 3'd6,
		KIND_READ     = 3'd7
	} kind_t;

	localparam logic [2:0] CAT_ARG  = 3'd1;
	localparam logic [2:0] CAT_EXT  = 3'd2;
	localparam logic [2:0] CAT_AUTO = 3'd3;
	localparam logic [2:0] CAT_INT  = 3'd4;

	// result word, entry_index in the lowest bits
	typedef struct packed {
		logic       entry_valid;
		logic [6:0] undefined_count;
		logic       table_full;
		logic       redeclared;
		logic [5:0] slot;
		logic       defined;
		logic [2:0] category;
		logic [5:0] entry_index;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} st_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### hdl/stdl_ram.sv
`default_nettype none

module stdl_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/stdl_ctrl.sv
`default_nettype none

module stdl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire stdl_pkg::sts_t sts,
	output stdl_pkg::cmd_t      cmd
);

	import stdl_pkg::*;

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// wait for the output register to be free
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/stdl_dp.sv
`default_nettype none

module stdl_dp #(
	parameter int TABLE_DEPTH = stdl_pkg::TABLE_DEPTH_DEF,
	parameter int NAME_WIDTH  = stdl_pkg::NAME_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stdl_pkg::cmd_t                cmd,
	output stdl_pkg::sts_t                     sts,
	input  wire logic [stdl_pkg::S_DATA_W-1:0] s_tdata,
	input  wire logic [stdl_pkg::KIND_W-1:0]   s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [stdl_pkg::M_DATA_W-1:0] m_tdata
);

	import stdl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = (CW > RIDX_W) ? CW : RIDX_W;
	localparam int EW = NAME_WIDTH + 10;

	kind_t                 kind_q;
	logic [NAME_WIDTH-1:0] name_q;
	logic [RIDX_W-1:0]     ridx_q;
	logic [CW-1:0]         count_q, count_d;
	logic [6:0]            arg_q, arg_d;
	logic [6:0]            slot_q, slot_d;
	logic [CW-1:0]         scan_idx_q, scan_end;
	logic                  rd_pend_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic                  found_q;
	logic [AW-1:0]         hit_idx_q;
	logic [2:0]            hit_cat_q;
	logic                  hit_def_q;
	logic [5:0]            hit_slot_q;
	logic [6:0]            undef_q;
	res_t                  res_q, res;
	logic                  m_tvalid_q;

	logic                  issue, hit, is_search, full, we;
	logic [AW-1:0]         rd_addr, w_idx;
	logic [EW-1:0]         rdata;
	logic [NAME_WIDTH-1:0] rd_name;
	logic [2:0]            rd_cat, w_cat;
	logic                  rd_def, w_def;
	logic [5:0]            rd_slot, w_slot;

	// entry word: name, category, defined mark, slot
	stdl_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.commit && we),
		.waddr(w_idx),
		.wdata({name_q, w_cat, w_def, w_slot}),
		.re   (issue),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign rd_name = rdata[EW-1:10];
	assign rd_cat  = rdata[9:7];
	assign rd_def  = rdata[6];
	assign rd_slot = rdata[5:0];

	assign is_search = kind_q inside {[KIND_ARG:KIND_LOOKUP]};
	assign full      = (count_q == CW'(TABLE_DEPTH));

	always_comb begin
		case (kind_q)
			KIND_CLEAR: scan_end = '0;
			KIND_READ:  scan_end = CW'(1);
			default:    scan_end = count_q;
		endcase
	end

	assign issue   = cmd.scan && !found_q && (scan_idx_q < scan_end);
	assign rd_addr = (kind_q == KIND_READ) ? AW'(ridx_q) : scan_idx_q[AW-1:0];
	assign hit     = rd_pend_s1 && !found_q &&
	                 ((kind_q == KIND_READ) || (is_search && (rd_name == name_q)));

	assign sts.scan_done = !rd_pend_s1 && (found_q || (scan_idx_q >= scan_end));
	assign sts.out_free  = !m_tvalid_q || m_tready;

	// result and table update at commit
	always_comb begin
		res     = '0;
		we      = 1'b0;
		w_idx   = count_q[AW-1:0];
		w_cat   = hit_cat_q;
		w_def   = hit_def_q;
		w_slot  = hit_slot_q;
		count_d = count_q;
		arg_d   = arg_q;
		slot_d  = slot_q;
		case (kind_q)
			KIND_CLEAR: begin
				count_d = '0;
				arg_d   = '0;
				slot_d  = '0;
			end
			KIND_COUNT: begin
				res.undefined_count = undef_q;
			end
			KIND_READ: begin
				if (RW'(ridx_q) < RW'(count_q)) begin
					res.entry_valid = 1'b1;
					res.entry_index = ridx_q;
					res.category    = hit_cat_q;
					res.defined     = hit_def_q;
					res.slot        = hit_slot_q;
				end
			end
			default: begin
				if (found_q) begin
					w_idx = hit_idx_q;
					case (kind_q)
						KIND_ARG, KIND_EXTERN, KIND_AUTO: begin
							res.redeclared = 1'b1;
						end
						KIND_INTERNAL: begin
							// an internal name made by a lookup may be defined once
							if (hit_cat_q == CAT_INT && !hit_def_q) begin
								we    = 1'b1;
								w_def = 1'b1;
							end else begin
								res.redeclared = 1'b1;
							end
						end
						default: ;
					endcase
					res.entry_index = 6'(hit_idx_q);
				end else if (full) begin
					res.table_full = 1'b1;
				end else begin
					we      = 1'b1;
					count_d = count_q + CW'(1);
					w_def   = 1'b1;
					w_slot  = slot_q[5:0];
					case (kind_q)
						KIND_ARG: begin
							w_cat  = CAT_ARG;
							w_slot = arg_q[5:0];
							arg_d  = arg_q + 7'd1;
						end
						KIND_EXTERN: begin
							w_cat  = CAT_EXT;
							w_slot = '0;
						end
						KIND_AUTO: begin
							w_cat  = CAT_AUTO;
							slot_d = slot_q + 7'd1;
						end
						KIND_INTERNAL: begin
							w_cat  = CAT_INT;
							slot_d = slot_q + 7'd1;
						end
						default: begin
							w_cat  = CAT_INT;
							w_def  = 1'b0;
							slot_d = slot_q + 7'd1;
						end
					endcase
					res.entry_index = 6'(count_q[AW-1:0]);
				end
				if (found_q || !full) begin
					res.category = w_cat;
					res.defined  = w_def;
					res.slot     = w_slot;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_CLEAR;
			count_q    <= '0;
			arg_q      <= '0;
			slot_q     <= '0;
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
			found_q    <= 1'b0;
			undef_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (cmd.load) begin
				kind_q     <= kind_t'(s_tuser);
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				undef_q    <= '0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (rd_pend_s1 && kind_q == KIND_COUNT && !rd_def && undef_q != 7'h7f) begin
					undef_q <= undef_q + 7'd1;
				end
			end
			if (cmd.commit) begin
				count_q    <= count_d;
				arg_q      <= arg_d;
				slot_q     <= slot_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			name_q <= NAME_WIDTH'(s_tdata[NAME_ID_W-1:0]);
			ridx_q <= s_tdata[NAME_ID_W +: RIDX_W];
		end
		rd_idx_s1 <= rd_addr;
		if (hit) begin
			hit_idx_q  <= rd_idx_s1;
			hit_cat_q  <= rd_cat;
			hit_def_q  <= rd_def;
			hit_slot_q <= rd_slot;
		end
		if (cmd.commit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(res_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(cmd.scan))
		else $error("table read outside a scan");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid_q)
		else $error("commit gave no result word");

	a_hit_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && kind_q != KIND_READ) |-> (CW'(hit_idx_q) < count_q))
		else $error("match found beyond filled entries");

endmodule

`default_nettype wire

### hdl/symbol_table_declare_lookup.sv
`default_nettype none

// symbol table with declare, lookup, clear, undefined count and entry read.
// one word in, one result word out. a search or count word reads the filled entries one per
// cycle through the single read port of the entry memory; an entry read reads only the
// addressed entry and clear reads none. the entries read are all the filled ones when the
// name is absent or for the undefined count, or those up to and including the match,
// with one more when entries follow the match because the next read is already under
// way. a result still waiting on the output holds back the next result, not the next word.
// entries come out of reset unwritten; no clearing pass is needed.
module symbol_table_declare_lookup #(
	parameter int TABLE_DEPTH = stdl_pkg::TABLE_DEPTH_DEF,
	parameter int NAME_WIDTH  = stdl_pkg::NAME_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// name_id [31:0], read_index [37:32]
	input  wire logic [stdl_pkg::S_DATA_W-1:0] s_tdata,
	// kind [2:0]
	input  wire logic [stdl_pkg::KIND_W-1:0]   s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// entry_index [5:0], category [8:6], defined [9], slot [15:10],
	// redeclared [16], table_full [17], undefined_count [24:18], entry_valid [25]
	output logic      [stdl_pkg::M_DATA_W-1:0] m_tdata
);

	import stdl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	stdl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	stdl_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.NAME_WIDTH (NAME_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire
